### design/ppd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_pkg
// Widths and constants shared by the planar pose distance block and its
// channel interfaces.
// ----------------------------------------------------------------------------
package ppd_pkg;

    localparam int POSITION_WIDTH = 24;
    localparam int HEADING_WIDTH  = 16;
    localparam int WEIGHT_WIDTH   = 16;
    localparam int DIST_WIDTH     = 25;

    localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_RESET = 16'd256;

    // position difference and its clamped magnitude
    localparam int DIFF_WIDTH  = POSITION_WIDTH + 1;
    localparam int CLAMP_WIDTH = 26;
    localparam int MAG_WIDTH   = (DIFF_WIDTH > CLAMP_WIDTH) ? CLAMP_WIDTH : DIFF_WIDTH;
    localparam logic [CLAMP_WIDTH-1:0] DIFF_CLAMP = '1;

    // squares, radicand and root
    localparam int SQ_WIDTH   = 2 * MAG_WIDTH;
    localparam int SUM_WIDTH  = SQ_WIDTH + 1;
    localparam int ROOT_WIDTH = (SUM_WIDTH + 1) / 2;
    localparam int RAD_WIDTH  = 2 * ROOT_WIDTH;
    localparam int REM_WIDTH  = ROOT_WIDTH + 2;

    // heading term
    localparam int HDIFF_WIDTH = HEADING_WIDTH + 1;
    localparam int ANGLE_WIDTH = 15;
    localparam int PROD_WIDTH  = ANGLE_WIDTH + WEIGHT_WIDTH;
    localparam int TURN_SHIFT  = 9;
    localparam int TURN_WIDTH  = PROD_WIDTH - TURN_SHIFT;

    localparam logic [HDIFF_WIDTH-1:0] PI_Q13     = 17'd25736;
    localparam logic [HDIFF_WIDTH-1:0] TWO_PI_Q13 = 17'd51472;

    // final sum before saturation
    localparam int TOTAL_WIDTH = ((ROOT_WIDTH > TURN_WIDTH) ? ROOT_WIDTH : TURN_WIDTH) + 1;
    localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;

endpackage

### design/ppd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_if
// Valid/ready channels of the planar pose distance block: the pose pair
// going in and the distance coming out.
// ----------------------------------------------------------------------------
interface ppd_pose_if;
    import ppd_pkg::*;

    logic                             valid;
    logic                             ready;
    logic signed [POSITION_WIDTH-1:0] first_x;
    logic signed [POSITION_WIDTH-1:0] first_y;
    logic signed [HEADING_WIDTH-1:0]  first_heading;
    logic signed [POSITION_WIDTH-1:0] second_x;
    logic signed [POSITION_WIDTH-1:0] second_y;
    logic signed [HEADING_WIDTH-1:0]  second_heading;

    modport source (
        output valid, first_x, first_y, first_heading,
        output second_x, second_y, second_heading,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_heading,
        input  second_x, second_y, second_heading,
        output ready
    );
endinterface

interface ppd_dist_if;
    import ppd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [DIST_WIDTH-1:0] pose_distance;

    modport source (output valid, pose_distance, input ready);
    modport sink (input valid, pose_distance, output ready);
endinterface

### design/planar_pose_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_pose_distance
// Distance between two planar poses: integer root of the squared position
// difference plus the weighted, wrapped heading difference.
// ----------------------------------------------------------------------------
// Usage:
//   i_pose carries one pose pair per beat (positions Q12.12, headings Q3.13).
//   o_dist returns one Q13.12 distance per pose pair, in order.
//   i_cfg_we / i_cfg_wdata write the Q8.8 heading weight; write it only
//   while no pose pair is in flight.
// Pipeline: four front stages take the differences, magnitudes, squares
//   and product, and the radicand sum; the root comes out of a chain of
//   ROOT_WIDTH stages that each decide one root bit; one register drives
//   the output.
// Throughput: one beat per cycle while o_dist is not stalled.
// Reset: all valid bits clear, the pipeline is empty and the weight
//   returns to 1.0 (256).
// Stall: while o_dist holds a beat that is not taken, the whole pipeline
//   holds and i_pose.ready is low; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module planar_pose_distance (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ppd_pkg::WEIGHT_WIDTH-1:0] i_cfg_wdata,
    ppd_pose_if.sink                   i_pose,
    ppd_dist_if.source                 o_dist
);
    import ppd_pkg::*;

    function automatic logic [MAG_WIDTH-1:0] clamp_mag(input logic signed [DIFF_WIDTH-1:0] d);
        logic [DIFF_WIDTH-1:0] m;
        logic [63:0]           ext;
        m   = d[DIFF_WIDTH-1] ? DIFF_WIDTH'(-d) : DIFF_WIDTH'(d);
        ext = 64'(m);
        return (ext > 64'(DIFF_CLAMP)) ? MAG_WIDTH'(DIFF_CLAMP) : MAG_WIDTH'(m);
    endfunction

    logic w_adv;

    logic [WEIGHT_WIDTH-1:0] r_angle_weight;

    // stage 1: differences
    logic                          r_s1_vld;
    logic signed [DIFF_WIDTH-1:0]  r_s1_dx, r_s1_dy;
    logic signed [HDIFF_WIDTH-1:0] r_s1_hd;
    // stage 2: magnitudes, wrapped heading
    logic                          r_s2_vld;
    logic [MAG_WIDTH-1:0]          r_s2_mx, r_s2_my;
    logic [ANGLE_WIDTH-1:0]        r_s2_ang;
    // stage 3: squares and weighted heading
    logic                          r_s3_vld;
    logic [SQ_WIDTH-1:0]           r_s3_sqx, r_s3_sqy;
    logic [PROD_WIDTH-1:0]         r_s3_prod;
    // root chain, index 0 is the entry
    logic                          r_vld  [0:ROOT_WIDTH];
    logic [RAD_WIDTH-1:0]          r_rad  [0:ROOT_WIDTH];
    logic [REM_WIDTH-1:0]          r_rem  [0:ROOT_WIDTH];
    logic [ROOT_WIDTH-1:0]         r_root [0:ROOT_WIDTH];
    logic [TURN_WIDTH-1:0]         r_turn [0:ROOT_WIDTH];
    // output register
    logic                          r_out_vld;
    logic [DIST_WIDTH-1:0]         r_out;

    logic [HDIFF_WIDTH-1:0]        n_habs;
    logic [ANGLE_WIDTH-1:0]        n_ang;
    logic [TOTAL_WIDTH-1:0]        n_total;
    logic [DIST_WIDTH-1:0]         n_out;

    // advance everything unless the output beat is stuck
    assign w_adv        = !r_out_vld || o_dist.ready;
    assign i_pose.ready = w_adv;
    assign o_dist.valid = r_out_vld;
    assign o_dist.pose_distance = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_weight <= WEIGHT_RESET;
        end else if (i_cfg_we) begin
            r_angle_weight <= i_cfg_wdata;
        end
    end

    always_comb begin
        n_habs = r_s1_hd[HDIFF_WIDTH-1] ? HDIFF_WIDTH'(-r_s1_hd) : HDIFF_WIDTH'(r_s1_hd);
        if (n_habs > TWO_PI_Q13) begin
            n_ang = ANGLE_WIDTH'(n_habs - TWO_PI_Q13);
        end else if (n_habs > PI_Q13) begin
            n_ang = ANGLE_WIDTH'(TWO_PI_Q13 - n_habs);
        end else begin
            n_ang = ANGLE_WIDTH'(n_habs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= i_pose.valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_vld[0] <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_dx   <= DIFF_WIDTH'(i_pose.first_x) - DIFF_WIDTH'(i_pose.second_x);
            r_s1_dy   <= DIFF_WIDTH'(i_pose.first_y) - DIFF_WIDTH'(i_pose.second_y);
            r_s1_hd   <= HDIFF_WIDTH'(i_pose.first_heading)
                         - HDIFF_WIDTH'(i_pose.second_heading);
            r_s2_mx   <= clamp_mag(r_s1_dx);
            r_s2_my   <= clamp_mag(r_s1_dy);
            r_s2_ang  <= n_ang;
            r_s3_sqx  <= SQ_WIDTH'(r_s2_mx) * SQ_WIDTH'(r_s2_mx);
            r_s3_sqy  <= SQ_WIDTH'(r_s2_my) * SQ_WIDTH'(r_s2_my);
            r_s3_prod <= PROD_WIDTH'(r_s2_ang) * PROD_WIDTH'(r_angle_weight);
            r_rad[0]  <= RAD_WIDTH'(SUM_WIDTH'(r_s3_sqx) + SUM_WIDTH'(r_s3_sqy));
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_turn[0] <= r_s3_prod[PROD_WIDTH-1:TURN_SHIFT];
        end
    end

    // one root bit per stage, two radicand bits brought down each time
    for (genvar s = 1; s <= ROOT_WIDTH; s++) begin : g_root
        logic [REM_WIDTH-1:0] cur;
        logic [REM_WIDTH-1:0] trial;
        logic                 take;

        always_comb begin
            cur   = {r_rem[s-1][REM_WIDTH-3:0], r_rad[s-1][RAD_WIDTH-1 -: 2]};
            trial = {r_root[s-1], 2'b01};
            take  = (cur >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (w_adv) begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_rad[s]  <= {r_rad[s-1][RAD_WIDTH-3:0], 2'b00};
                r_rem[s]  <= take ? (cur - trial) : cur;
                r_root[s] <= {r_root[s-1][ROOT_WIDTH-2:0], take};
                r_turn[s] <= r_turn[s-1];
            end
        end
    end

    always_comb begin
        n_total = TOTAL_WIDTH'(r_root[ROOT_WIDTH]) + TOTAL_WIDTH'(r_turn[ROOT_WIDTH]);
        if (64'(n_total) > 64'(DIST_MAX)) begin
            n_out = DIST_MAX;
        end else begin
            n_out = DIST_WIDTH'(n_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_vld[ROOT_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for planar_pose_distance: drives pose pairs with random
// gaps, stalls the distance channel at random, predicts every distance from
// the current heading weight and compares the results in order. The weight
// is rewritten between phases once the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_top;
    import ppd_pkg::*;

    localparam int PERIOD_HALF    = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int ITEMS_PER_WGT  = 210;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 1000;

    localparam int POS_MAX  = 2 ** (POSITION_WIDTH - 1) - 1;
    localparam int POS_MIN  = -(2 ** (POSITION_WIDTH - 1));
    localparam int HEAD_MAX = 2 ** (HEADING_WIDTH - 1) - 1;
    localparam int HEAD_MIN = -(2 ** (HEADING_WIDTH - 1));
    localparam int PI_INT   = 25736;

    typedef struct {
        logic signed [POSITION_WIDTH-1:0] first_x;
        logic signed [POSITION_WIDTH-1:0] first_y;
        logic signed [HEADING_WIDTH-1:0]  first_heading;
        logic signed [POSITION_WIDTH-1:0] second_x;
        logic signed [POSITION_WIDTH-1:0] second_y;
        logic signed [HEADING_WIDTH-1:0]  second_heading;
    } t_pose_pair;

    // Holds the heading weight and the distances still owed by the block.
    class t_distance_tracker;
        logic [WEIGHT_WIDTH-1:0] weight = WEIGHT_RESET;
        logic [DIST_WIDTH-1:0]   expected_dist[$];
        int                      errors = 0;

        function void set_weight(logic [WEIGHT_WIDTH-1:0] w);
            weight = w;
        endfunction

        function int pending();
            return expected_dist.size();
        endfunction

        // Floor root, one bit at a time from the top.
        function longint unsigned floor_root(longint unsigned n);
            longint unsigned r;
            longint unsigned trial;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                trial = r | (64'd1 << b);
                if (trial * trial <= n)
                    r = trial;
            end
            return r;
        endfunction

        function logic [DIST_WIDTH-1:0] predict_distance(t_pose_pair p);
            longint          dx;
            longint          dy;
            longint          hd;
            longint unsigned root;
            longint unsigned ang;
            longint unsigned turn;
            longint unsigned total;
            dx = longint'(p.first_x) - longint'(p.second_x);
            dy = longint'(p.first_y) - longint'(p.second_y);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dx > longint'(DIFF_CLAMP)) dx = longint'(DIFF_CLAMP);
            if (dy > longint'(DIFF_CLAMP)) dy = longint'(DIFF_CLAMP);
            root = floor_root(longint'(dx * dx + dy * dy));

            hd = longint'(p.first_heading) - longint'(p.second_heading);
            if (hd < 0) hd = -hd;
            ang = hd;
            // fold onto [0, pi]; beyond 2pi only happens off the nominal range
            if (ang > TWO_PI_Q13)
                ang = ang - TWO_PI_Q13;
            else if (ang > PI_Q13)
                ang = TWO_PI_Q13 - ang;
            turn = (ang * longint'(weight)) >> TURN_SHIFT;

            total = root + turn;
            if (total > DIST_MAX)
                total = DIST_MAX;
            return total[DIST_WIDTH-1:0];
        endfunction

        function void note_pose(t_pose_pair p);
            expected_dist = {expected_dist, predict_distance(p)};
        endfunction

        function void check_distance(logic [DIST_WIDTH-1:0] actual);
            logic [DIST_WIDTH-1:0] want;
            if (expected_dist.size() == 0) begin
                $error("pose_distance: unexpected beat, actual %0d", actual);
                errors++;
                return;
            end
            want = expected_dist.pop_front();
            if (actual !== want) begin
                $error("pose_distance mismatch: expected %0d, actual %0d", want, actual);
                errors++;
            end
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_we;
    logic [WEIGHT_WIDTH-1:0] cfg_wdata;
    bit                      src_steady = 1'b0;
    bit                      snk_steady = 1'b0;
    int                      quiet_cycles = 0;
    t_distance_tracker       tracker = new();

    ppd_pose_if pose_ch();
    ppd_dist_if dist_ch();

    planar_pose_distance dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_pose      (pose_ch),
        .o_dist      (dist_ch)
    );

    always begin
        #PERIOD_HALF clk = 1'b1;
        #PERIOD_HALF clk = 1'b0;
    end

    function automatic t_pose_pair make_pose(int fx, int fy, int fh, int sx, int sy, int sh);
        t_pose_pair p;
        p.first_x        = POSITION_WIDTH'(fx);
        p.first_y        = POSITION_WIDTH'(fy);
        p.first_heading  = HEADING_WIDTH'(fh);
        p.second_x       = POSITION_WIDTH'(sx);
        p.second_y       = POSITION_WIDTH'(sy);
        p.second_heading = HEADING_WIDTH'(sh);
        return p;
    endfunction

    function automatic int rand_position();
        case ($urandom_range(0, 5))
            0:       return POS_MAX;
            1:       return POS_MIN;
            2:       return int'($urandom_range(0, 511)) - 256;
            default: return int'($urandom);
        endcase
    endfunction

    function automatic int rand_heading();
        case ($urandom_range(0, 15))
            0:       return PI_INT;
            1:       return -PI_INT;
            2:       return 0;
            3:       return int'($urandom_range(0, 63)) - 32;
            // off the nominal range: exercise the beyond-2pi fold
            4:       return int'($urandom_range(0, 65535)) + HEAD_MIN;
            default: return int'($urandom_range(0, 2 * PI_INT)) - PI_INT;
        endcase
    endfunction

    function automatic t_pose_pair rand_pose();
        t_pose_pair p;
        p = make_pose(rand_position(), rand_position(), rand_heading(),
                      rand_position(), rand_position(), rand_heading());
        // close pairs give small roots where rounding of the root matters
        if ($urandom_range(0, 3) == 0) begin
            p.second_x = POSITION_WIDTH'(p.first_x + (int'($urandom_range(0, 4095)) - 2048));
            p.second_y = POSITION_WIDTH'(p.first_y + (int'($urandom_range(0, 4095)) - 2048));
        end
        return p;
    endfunction

    task automatic send_pose(t_pose_pair p);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 7);
        repeat (gap) begin
            @(negedge clk);
            pose_ch.valid = 1'b0;
        end
        @(negedge clk);
        pose_ch.valid          = 1'b1;
        pose_ch.first_x        = p.first_x;
        pose_ch.first_y        = p.first_y;
        pose_ch.first_heading  = p.first_heading;
        pose_ch.second_x       = p.second_x;
        pose_ch.second_y       = p.second_y;
        pose_ch.second_heading = p.second_heading;
        do @(posedge clk); while (pose_ch.ready !== 1'b1);
        tracker.note_pose(p);
        if ($urandom_range(0, 63) == 0)
            src_steady = !src_steady;
    endtask

    // Drop valid and hold until every owed distance has come back.
    task automatic drain();
        @(negedge clk);
        pose_ch.valid = 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_weight(logic [WEIGHT_WIDTH-1:0] w);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = w;
        @(negedge clk);
        cfg_we = 1'b0;
        tracker.set_weight(w);
    endtask

    task automatic run_directed();
        send_pose(make_pose(0, 0, 0, 0, 0, 0));
        send_pose(make_pose(POS_MAX, POS_MAX, PI_INT, POS_MIN, POS_MIN, -PI_INT));
        send_pose(make_pose(POS_MIN, POS_MAX, -PI_INT, POS_MAX, POS_MIN, PI_INT));
        send_pose(make_pose(POS_MAX, 0, PI_INT, POS_MIN, 0, 0));
        send_pose(make_pose(0, POS_MIN, 0, 0, POS_MAX, -PI_INT));
        send_pose(make_pose(3, 4, PI_INT, 0, 0, -1));
        send_pose(make_pose(-1, -1, -PI_INT, 1, 0, 1));
        send_pose(make_pose(1, 0, 1, 0, 0, 0));
        send_pose(make_pose(1, 1, 0, 0, 0, 0));
        send_pose(make_pose(2, 0, PI_INT, 0, 0, PI_INT));
        send_pose(make_pose(-1, -1, -1, -1, -1, -1));
        send_pose(make_pose(POS_MAX, POS_MAX, HEAD_MAX, POS_MAX, POS_MAX, HEAD_MAX));
        send_pose(make_pose(POS_MIN, POS_MIN, HEAD_MIN, POS_MIN, POS_MIN, HEAD_MIN));
        send_pose(make_pose(0, 0, HEAD_MAX, 0, 0, HEAD_MIN));
        send_pose(make_pose(0, 0, HEAD_MIN, 0, 0, 0));
        send_pose(make_pose(0, 0, HEAD_MAX, 0, 0, -PI_INT));
        send_pose(make_pose(4096, -4096, 8192, -4096, 4096, -8192));
        send_pose(make_pose(12345, -54321, 100, -777, 999, -100));
        send_pose(make_pose(POS_MAX, POS_MIN, 1, POS_MIN, POS_MAX, 0));
        send_pose(make_pose(0, 0, PI_INT + 1, 0, 0, -PI_INT));
    endtask

    task automatic run_random(int count);
        repeat (count) send_pose(rand_pose());
    endtask

    initial begin : sink_side
        int stall;
        dist_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            stall = snk_steady ? 0 : $urandom_range(0, 7);
            repeat (stall) begin
                @(negedge clk);
                dist_ch.ready = 1'b0;
            end
            @(negedge clk);
            dist_ch.ready = 1'b1;
            do @(posedge clk); while (dist_ch.valid !== 1'b1);
            if ($urandom_range(0, 63) == 0)
                snk_steady = !snk_steady;
        end
    end

    always @(posedge clk) begin
        if (rst_n === 1'b1 && dist_ch.valid === 1'b1 && dist_ch.ready === 1'b1)
            tracker.check_distance(dist_ch.pose_distance);
    end

    always @(posedge clk) begin
        if ((pose_ch.valid === 1'b1 && pose_ch.ready === 1'b1) ||
            (dist_ch.valid === 1'b1 && dist_ch.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin : source_side
        logic [WEIGHT_WIDTH-1:0] weights[8];
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_wdata              = '0;
        pose_ch.valid          = 1'b0;
        pose_ch.first_x        = '0;
        pose_ch.first_y        = '0;
        pose_ch.first_heading  = '0;
        pose_ch.second_x       = '0;
        pose_ch.second_y       = '0;
        pose_ch.second_heading = '0;

        weights[0] = 16'hFFFF;
        weights[1] = 16'h0000;
        weights[2] = 16'd1;
        weights[3] = WEIGHT_WIDTH'($urandom_range(0, 65535));
        weights[4] = 16'h8000;
        weights[5] = WEIGHT_WIDTH'($urandom_range(0, 1023));
        weights[6] = WEIGHT_WIDTH'($urandom_range(0, 65535));
        weights[7] = WEIGHT_RESET;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // reset weight first, untouched
        run_directed();
        drain();

        foreach (weights[i]) begin
            write_weight(weights[i]);
            run_random(ITEMS_PER_WGT);
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### files.f
design/ppd_pkg.sv
design/ppd_if.sv
design/planar_pose_distance.sv
bench/tb_top.sv
